FILE: hdl/tcsd_pkg.sv
// Types, codes and digit step functions for the timecode step and direction unit.
package tcsd_pkg;

    localparam logic [31:0] VALID_MASK = 32'h3f7f7f3f;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 5;
    localparam logic [4:0]  FPS_RESET  = 5'd30;
    localparam logic [5:0]  HOURS_DAY  = 6'd24;

    typedef enum logic [1:0] {
        ACT_INCR = 2'd0,
        ACT_DECR = 2'd1,
        ACT_DIR  = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        DIR_NONE     = 2'd0,
        DIR_FOLLOWS  = 2'd1,
        DIR_PRECEDES = 2'd2
    } t_dir;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_RATE = 1'd0,
        REG_DROP_FRAME = 1'd1
    } t_reg_idx;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] code_a;
        logic [31:0] code_b;
    } t_tcsd_req;

    typedef struct packed {
        logic [29:0] result_code;
        logic [1:0]  direction;
    } t_tcsd_rsp;

    typedef struct packed {
        logic [4:0] fps;
        logic       drop_frame;
    } t_tcsd_cfg;

    // Advances a timecode word by one frame; fps is already at least one.
    function automatic logic [29:0] tc_incr(input logic [31:0] a, input logic [4:0] fps,
                                            input logic drop);
        logic [4:0] f;
        logic [2:0] ft;
        logic [5:0] fval;
        logic [4:0] s;
        logic [3:0] st;
        logic [4:0] m;
        logic [3:0] mt;
        logic [4:0] h;
        logic [2:0] ht;
        logic [5:0] hval;
        logic [3:0] fo;
        logic [29:0] res;
        begin
            f    = {1'b0, a[3:0]} + 5'd1;
            ft   = {1'b0, a[5:4]};
            if (f >= 5'd10) begin
                ft = ft + 3'd1;
                f  = '0;
            end
            fval = 6'(ft) * 6'd10 + 6'(f);
            if (fval < {1'b0, fps}) begin
                res = {a[29:24], 1'b0, a[22:16], 1'b0, a[14:8], 2'b00, ft[1:0], f[3:0]};
            end else begin
                fo = 4'd0;
                s  = {1'b0, a[11:8]} + 5'd1;
                st = {1'b0, a[14:12]};
                m  = {1'b0, a[19:16]};
                mt = {1'b0, a[22:20]};
                h  = {1'b0, a[27:24]};
                ht = {1'b0, a[29:28]};
                if (s >= 5'd10) begin
                    s  = '0;
                    st = st + 4'd1;
                    if (st >= 4'd6) begin
                        st = '0;
                        m  = m + 5'd1;
                        if (m >= 5'd10) begin
                            m  = '0;
                            mt = mt + 4'd1;
                            if (mt >= 4'd6) begin
                                mt = '0;
                                h  = h + 5'd1;
                                if (h >= 5'd10) begin
                                    h  = '0;
                                    ht = ht + 3'd1;
                                end
                                hval = 6'(ht) * 6'd10 + 6'(h);
                                if (hval >= HOURS_DAY) begin
                                    ht = '0;
                                    h  = '0;
                                end
                            end
                        end else if (drop) begin
                            fo = 4'd2;
                        end
                    end
                end
                res = {ht[1:0], h[3:0], 1'b0, mt[2:0], m[3:0], 1'b0, st[2:0], s[3:0],
                       2'b00, 2'b00, fo};
            end
            return res;
        end
    endfunction

    // Moves a timecode word back by one frame; fps is already at least one.
    function automatic logic [29:0] tc_decr(input logic [31:0] a, input logic [4:0] fps,
                                            input logic drop);
        logic signed [5:0] fd;
        logic [4:0] last;
        logic [1:0] ft;
        logic [3:0] f;
        logic [3:0] s;
        logic [2:0] st;
        logic [3:0] m;
        logic [2:0] mt;
        logic [3:0] h;
        logic [1:0] ht;
        logic [29:0] res;
        begin
            fd = $signed({2'b00, a[3:0]}) - 6'sd1;
            if (drop && (fd < 6'sd2) && (a[14:4] == '0) && (a[19:16] != '0)) begin
                fd = fd - 6'sd2;
            end
            if (fd >= 6'sd0) begin
                res = {a[29:24], 1'b0, a[22:16], 1'b0, a[14:8], 2'b00, a[5:4], fd[3:0]};
            end else begin
                s  = a[11:8];
                st = a[14:12];
                m  = a[19:16];
                mt = a[22:20];
                h  = a[27:24];
                ht = a[29:28];
                if (a[5:4] != 2'd0) begin
                    ft = a[5:4] - 2'd1;
                    f  = 4'd9;
                end else begin
                    last = fps - 5'd1;
                    if (last >= 5'd30) begin
                        ft = 2'd3;
                    end else if (last >= 5'd20) begin
                        ft = 2'd2;
                    end else if (last >= 5'd10) begin
                        ft = 2'd1;
                    end else begin
                        ft = 2'd0;
                    end
                    f = 4'(last - 5'(ft) * 5'd10);
                    if (s == '0) begin
                        s = 4'd9;
                        if (st == '0) begin
                            st = 3'd5;
                            if (m == '0) begin
                                m = 4'd9;
                                if (mt == '0) begin
                                    mt = 3'd5;
                                    if (h == '0) begin
                                        h = 4'd9;
                                        if (ht == '0) begin
                                            ht = 2'd2;
                                            h  = 4'd3;
                                        end else begin
                                            ht = ht - 2'd1;
                                        end
                                    end else begin
                                        h = h - 4'd1;
                                    end
                                end else begin
                                    mt = mt - 3'd1;
                                end
                            end else begin
                                m = m - 4'd1;
                            end
                        end else begin
                            st = st - 3'd1;
                        end
                    end else begin
                        s = s - 4'd1;
                    end
                end
                res = {ht, h, 1'b0, mt, m, 1'b0, st, s, 2'b00, ft, f};
            end
            return res;
        end
    endfunction

endpackage

FILE: hdl/tcsd_step.sv
// Combinational step and direction logic for one registered request.
module tcsd_step (
    input  tcsd_pkg::t_tcsd_req i_req,
    input  tcsd_pkg::t_tcsd_cfg i_cfg,
    output tcsd_pkg::t_tcsd_rsp o_rsp
);
    import tcsd_pkg::*;

    logic [4:0]  fps_eff;
    logic [29:0] incr_a;
    logic [29:0] incr_b;
    logic [29:0] decr_a;
    logic [31:0] raw_next;
    logic [31:0] b_valid;
    logic [31:0] a_valid;
    t_dir        dir;

    assign fps_eff  = (i_cfg.fps == '0) ? 5'd1 : i_cfg.fps;
    assign incr_a   = tc_incr(i_req.code_a, fps_eff, i_cfg.drop_frame);
    assign incr_b   = tc_incr(i_req.code_b, fps_eff, i_cfg.drop_frame);
    assign decr_a   = tc_decr(i_req.code_a, fps_eff, i_cfg.drop_frame);
    assign raw_next = i_req.code_a + 32'd1;
    assign b_valid  = i_req.code_b & VALID_MASK;
    assign a_valid  = i_req.code_a & VALID_MASK;

    always_comb begin
        if (((raw_next & VALID_MASK) == b_valid) ||
            (({2'b00, incr_a} & VALID_MASK) == b_valid)) begin
            dir = DIR_FOLLOWS;
        end else if (({2'b00, incr_b} & VALID_MASK) == a_valid) begin
            dir = DIR_PRECEDES;
        end else begin
            dir = DIR_NONE;
        end
    end

    always_comb begin
        o_rsp = '0;
        case (t_action'(i_req.action))
            ACT_INCR: begin
                o_rsp.result_code = incr_a;
            end
            ACT_DECR: begin
                o_rsp.result_code = decr_a;
            end
            ACT_DIR: begin
                o_rsp.direction = dir;
            end
            default: begin
                o_rsp = '0;
            end
        endcase
    end

endmodule

FILE: hdl/timecode_step_and_direction.sv
// Top level of the timecode step and direction unit with its request pipeline.
// Takes one request per clock while the output is not stalled and returns one result per
// request, in order: a request register feeds the digit carry and borrow logic, whose
// result lands in an output register. Both registers move independently, so a new
// request is taken while a finished result waits to be read if the request register is empty.
// The user writes configuration (index 0 frame rate, index 1 drop-frame enable) only while idle; not enforced here.
module timecode_step_and_direction (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_req_valid,
    output logic                                 o_req_ready,
    input  tcsd_pkg::t_tcsd_req                  i_req,
    output logic                                 o_rsp_valid,
    input  logic                                 i_rsp_ready,
    output tcsd_pkg::t_tcsd_rsp                  o_rsp,
    input  logic                                 i_cfg_we,
    input  logic [tcsd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tcsd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import tcsd_pkg::*;

    t_tcsd_cfg r_cfg;
    logic      r_in_valid;
    t_tcsd_req r_in;
    logic      r_out_valid;
    t_tcsd_rsp r_out;
    t_tcsd_rsp step_rsp;
    logic      out_load;
    logic      n_in_valid;
    logic      n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fps        <= FPS_RESET;
            r_cfg.drop_frame <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_FRAME_RATE: r_cfg.fps        <= i_cfg_data;
                REG_DROP_FRAME: r_cfg.drop_frame <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign out_load    = r_in_valid && (!r_out_valid || i_rsp_ready);
    assign o_req_ready = !r_in_valid || out_load;
    assign n_in_valid  = o_req_ready ? i_req_valid : r_in_valid;
    assign n_out_valid = out_load ? 1'b1 : (i_rsp_ready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_valid && o_req_ready) begin
            r_in <= i_req;
        end
        if (out_load) begin
            r_out <= step_rsp;
        end
    end

    tcsd_step u_step (
        .i_req (r_in),
        .i_cfg (r_cfg),
        .o_rsp (step_rsp)
    );

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> r_in_valid)
        else $error("accepted request did not reach the request register");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_rsp_valid)
        else $error("computed result did not reach the output");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !i_rsp_ready |-> !o_req_ready)
        else $error("request taken while both stages are held");

    a_one_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.result_code == '0) || (o_rsp.direction == DIR_NONE))
        else $error("result carries both a code and a direction");

endmodule
